/* rtl/ldw_pkg.sv */
// Shared types, constants and command table for the LED driver two-wire write master.
// No dependencies; imported by ldw_core, the top level and the testbench.
package ldw_pkg;

  localparam int POS_W = 3;
  localparam int PH_W  = 4;

  localparam logic [PH_W-1:0] PH_IDLE  = 4'd0;
  localparam logic [PH_W-1:0] PH_BITA  = 4'd1;
  localparam logic [PH_W-1:0] PH_BITB  = 4'd2;
  localparam logic [PH_W-1:0] PH_BITC  = 4'd3;
  localparam logic [PH_W-1:0] PH_ACK0  = 4'd4;
  localparam logic [PH_W-1:0] PH_ACK1  = 4'd5;
  localparam logic [PH_W-1:0] PH_ACK2  = 4'd6;
  localparam logic [PH_W-1:0] PH_ACK3  = 4'd7;
  localparam logic [PH_W-1:0] PH_STOP0 = 4'd8;
  localparam logic [PH_W-1:0] PH_STOP1 = 4'd9;
  localparam logic [PH_W-1:0] PH_STOP2 = 4'd10;

  localparam logic [1:0] BYTE_MODE = 2'd0;
  localparam logic [1:0] BYTE_ADDR = 2'd1;
  localparam logic [1:0] BYTE_DATA = 2'd2;
  localparam logic [1:0] BYTE_CTRL = 2'd3;

  localparam logic [7:0] CMD_MODE = 8'h44;
  localparam logic [7:0] CMD_ADDR = 8'hC0;
  localparam logic [7:0] CMD_CTRL = 8'h88;

  localparam int DRV_CLK = 0;
  localparam int DRV_DIO = 1;

  localparam logic [2:0] BRIGHT_RST = 3'd7;

  typedef struct packed {
    logic [PH_W-1:0]  phase;
    logic [2:0]       bit_idx;
    logic [7:0]       shift;
    logic [1:0]       byte_num;
    logic [POS_W-1:0] hpos;
    logic [7:0]       hseg;
    logic             ack_fail;
    logic [1:0]       drive;
  } ldw_state_t;

  typedef struct packed {
    logic clk_pull_low;
    logic dio_pull_low;
    logic busy;
    logic done;
    logic ack_missing;
  } ldw_res_t;

  function automatic logic [7:0] cmd_byte(input logic [1:0] n, input logic [POS_W-1:0] pos,
                                          input logic [7:0] seg, input logic [2:0] bri);
    logic [7:0] b;
    case (n)
      BYTE_MODE: b = CMD_MODE;
      BYTE_ADDR: b = CMD_ADDR | {{(8-POS_W){1'b0}}, pos};
      BYTE_DATA: b = seg;
      default:   b = CMD_CTRL | {5'b0, bri};
    endcase
    return b;
  endfunction

endpackage

/* rtl/ldw_core.sv */
// Bus sequencer state and its one-tick step logic.
// Depends on ldw_pkg.
module ldw_core (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step_en,
  input  logic                    request,
  input  logic [ldw_pkg::POS_W-1:0] position,
  input  logic [7:0]              segments,
  input  logic                    dio_sense,
  input  logic [2:0]              brightness,
  output ldw_pkg::ldw_res_t       res
);
  import ldw_pkg::*;

  ldw_state_t st_r, st_nxt;
  logic       done;

  always_comb begin
    st_nxt = st_r;
    done   = 1'b0;
    unique case (st_r.phase)
      PH_IDLE: begin
        if (request) begin
          st_nxt.hpos     = position;
          st_nxt.hseg     = segments;
          st_nxt.ack_fail = 1'b0;
          st_nxt.drive    = 2'b00;
          st_nxt.drive[DRV_DIO] = 1'b1;
          st_nxt.byte_num = BYTE_MODE;
          st_nxt.shift    = cmd_byte(BYTE_MODE, position, segments, brightness);
          st_nxt.bit_idx  = 3'd0;
          st_nxt.phase    = PH_BITA;
        end else begin
          st_nxt.drive = 2'b00;
        end
      end
      PH_BITA: begin
        st_nxt.drive[DRV_CLK] = 1'b1;
        st_nxt.phase = PH_BITB;
      end
      PH_BITB: begin
        st_nxt.drive[DRV_DIO] = ~st_r.shift[0];
        st_nxt.phase = PH_BITC;
      end
      PH_BITC: begin
        st_nxt.drive[DRV_CLK] = 1'b0;
        st_nxt.shift = {1'b0, st_r.shift[7:1]};
        if (st_r.bit_idx == 3'd7) begin
          st_nxt.bit_idx = 3'd0;
          st_nxt.phase   = PH_ACK0;
        end else begin
          st_nxt.bit_idx = st_r.bit_idx + 3'd1;
          st_nxt.phase   = PH_BITA;
        end
      end
      PH_ACK0: begin
        st_nxt.drive = 2'b00;
        st_nxt.drive[DRV_CLK] = 1'b1;
        st_nxt.phase = PH_ACK1;
      end
      PH_ACK1: begin
        st_nxt.drive[DRV_CLK] = 1'b0;
        st_nxt.phase = PH_ACK2;
      end
      PH_ACK2: begin
        if (!dio_sense) st_nxt.drive[DRV_DIO] = 1'b1;
        else            st_nxt.ack_fail = 1'b1;
        st_nxt.phase = PH_ACK3;
      end
      PH_ACK3: begin
        st_nxt.drive[DRV_CLK] = 1'b1;
        if (st_r.byte_num == BYTE_ADDR) begin
          st_nxt.byte_num = BYTE_DATA;
          st_nxt.shift    = cmd_byte(BYTE_DATA, st_r.hpos, st_r.hseg, brightness);
          st_nxt.bit_idx  = 3'd0;
          st_nxt.phase    = PH_BITA;
        end else begin
          st_nxt.phase = PH_STOP0;
        end
      end
      PH_STOP0: begin
        st_nxt.drive[DRV_DIO] = 1'b1;
        st_nxt.phase = PH_STOP1;
      end
      PH_STOP1: begin
        st_nxt.drive[DRV_CLK] = 1'b0;
        st_nxt.phase = PH_STOP2;
      end
      PH_STOP2: begin
        st_nxt.drive = 2'b00;
        if (st_r.byte_num == BYTE_CTRL) begin
          st_nxt.phase    = PH_IDLE;
          st_nxt.byte_num = BYTE_MODE;
          done            = 1'b1;
        end else begin
          st_nxt.drive[DRV_DIO] = 1'b1;
          st_nxt.byte_num = st_r.byte_num + 2'd1;
          st_nxt.shift    = cmd_byte(st_r.byte_num + 2'd1, st_r.hpos, st_r.hseg, brightness);
          st_nxt.bit_idx  = 3'd0;
          st_nxt.phase    = PH_BITA;
        end
      end
      default: begin
        st_nxt.phase = PH_IDLE;
        st_nxt.drive = 2'b00;
      end
    endcase
  end

  always_comb begin
    res.clk_pull_low = st_nxt.drive[DRV_CLK];
    res.dio_pull_low = st_nxt.drive[DRV_DIO];
    res.busy         = (st_nxt.phase != PH_IDLE);
    res.done         = done;
    res.ack_missing  = st_nxt.ack_fail;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (step_en) begin
      st_r <= st_nxt;
    end
  end

endmodule

/* rtl/led_driver_two_wire_write_master_unit.sv */
// Top level of the LED driver two-wire write master: input register, sequencer, result register.
// Depends on ldw_pkg and ldw_core.
//
// Usage:
//   Each request on the in_ channel is one bit-time tick of the bus. A tick
//   with in_request high while the sequencer is idle starts a write of three
//   framed commands (mode, address plus segment byte, display control with
//   the brightness register); while busy in_request is ignored.
//   Every tick yields exactly one result on the out_ channel: the pull-low
//   levels of both lines, busy, a done pulse and the sticky missing-ack flag.
//   cfg_we writes the 3-bit brightness register in the same cycle; write it
//   only while idle.
//   The result passes through the input register, then the sequencer step
//   into the result register. Throughput: one tick per cycle while out_ready
//   is not held low, set by the step of the sequencer state.
//   When out_ready is low the result is held and one more tick may wait in
//   the input register; in_ready drops only when both are full.
//   Reset (rst_n low, synchronous) empties both registers, idles the
//   sequencer with both lines released and sets brightness to 7.
module led_driver_two_wire_write_master_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_request,
  input  logic [ldw_pkg::POS_W-1:0] in_position,
  input  logic [7:0]                in_segments,
  input  logic                      in_dio_sense,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_clk_pull_low,
  output logic                      out_dio_pull_low,
  output logic                      out_busy_res,
  output logic                      out_done_res,
  output logic                      out_ack_missing,
  input  logic                      cfg_we,
  input  logic [2:0]                cfg_wdata
);
  import ldw_pkg::*;

  logic             in_v_r;
  logic             req_r;
  logic [POS_W-1:0] pos_r;
  logic [7:0]       seg_r;
  logic             sense_r;
  logic             out_v_r, out_v_nxt;
  ldw_res_t         res_r, res;
  logic [2:0]       bright_r;
  logic             fire;

  assign fire     = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || fire;

  ldw_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (fire),
    .request    (req_r),
    .position   (pos_r),
    .segments   (seg_r),
    .dio_sense  (sense_r),
    .brightness (bright_r),
    .res        (res)
  );

  always_comb begin
    if (fire)           out_v_nxt = 1'b1;
    else if (out_ready) out_v_nxt = 1'b0;
    else                out_v_nxt = out_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      bright_r <= BRIGHT_RST;
    end else begin
      if (in_ready) in_v_r <= in_valid;
      out_v_r <= out_v_nxt;
      if (cfg_we) bright_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r   <= in_request;
      pos_r   <= in_position;
      seg_r   <= in_segments;
      sense_r <= in_dio_sense;
    end
    if (fire) res_r <= res;
  end

  assign out_valid        = out_v_r;
  assign out_clk_pull_low = res_r.clk_pull_low;
  assign out_dio_pull_low = res_r.dio_pull_low;
  assign out_busy_res     = res_r.busy;
  assign out_done_res     = res_r.done;
  assign out_ack_missing  = res_r.ack_missing;

endmodule

/* rtl/ldw_chk.sv */
// Port-level checker for the LED driver two-wire write master, bound to the top level.
// Depends on led_driver_two_wire_write_master_unit.
module ldw_chk (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      out_clk_pull_low,
  input logic                      out_dio_pull_low,
  input logic                      out_busy_res,
  input logic                      out_done_res,
  input logic                      out_ack_missing
);

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_clk_pull_low) &&
      $stable(out_dio_pull_low) && $stable(out_busy_res) && $stable(out_done_res) &&
      $stable(out_ack_missing))
    else $error("stalled request changed");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_busy_res)
    else $error("done while still busy");

  a_idle_released: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_busy_res |-> !out_clk_pull_low && !out_dio_pull_low)
    else $error("line pulled low while idle");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind led_driver_two_wire_write_master_unit ldw_chk u_ldw_chk (.*);

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// Testbench for led_driver_two_wire_write_master_unit: drives bit-time tick requests, predicts
// the line levels, busy, done and missing-ack flag, and checks every result in order.
// Depends on ldw_pkg and the rtl top level.
module tb_top;
  import ldw_pkg::*;

  localparam logic [1:0] BUSY_QUIET  = 2'd0;
  localparam logic [1:0] BUSY_SOME   = 2'd1;
  localparam logic [1:0] BUSY_ALWAYS = 2'd2;

  localparam ldw_res_t RES_IDLE  = '0;
  localparam ldw_res_t RES_START = '{clk_pull_low: 1'b0, dio_pull_low: 1'b1, busy: 1'b1,
                                     done: 1'b0, ack_missing: 1'b0};

  typedef struct packed {
    logic             req;
    logic [POS_W-1:0] pos;
    logic [7:0]       seg;
    logic [3:0]       nack;      // bytes answered high, by byte number
    logic [1:0]       busy_req;
    logic [2:0]       bri;
    logic             typed;
    ldw_res_t         first;
  } dir_row_t;

  localparam int NUM_ROWS = 6;

  dir_row_t dir_rows [0:NUM_ROWS-1] = '{
    '{1'b0, 3'd7, 8'hFF, 4'hF, BUSY_QUIET,  3'd7, 1'b1, RES_IDLE},
    '{1'b0, 3'd0, 8'h00, 4'h0, BUSY_QUIET,  3'd7, 1'b1, RES_IDLE},
    '{1'b1, 3'd0, 8'h00, 4'h0, BUSY_QUIET,  3'd7, 1'b1, RES_START},
    '{1'b1, 3'd7, 8'hFF, 4'hF, BUSY_ALWAYS, 3'd7, 1'b1, RES_START},
    '{1'b1, 3'd2, 8'h3C, 4'h4, BUSY_SOME,   3'd0, 1'b0, RES_IDLE},
    '{1'b0, 3'd3, 8'h5A, 4'h0, BUSY_QUIET,  3'd0, 1'b0, RES_IDLE}
  };

  logic [2:0] bri_plan [0:2] = '{3'd2, 3'd5, 3'd1};

  logic             clk;
  logic             rst_n        = 1'b0;
  logic             in_valid     = 1'b0;
  logic             in_ready;
  logic             in_request   = 1'b0;
  logic [POS_W-1:0] in_position  = '0;
  logic [7:0]       in_segments  = '0;
  logic             in_dio_sense = 1'b0;
  logic             out_valid;
  logic             out_ready    = 1'b0;
  logic             out_clk_pull_low;
  logic             out_dio_pull_low;
  logic             out_busy_res;
  logic             out_done_res;
  logic             out_ack_missing;
  logic             cfg_we       = 1'b0;
  logic [2:0]       cfg_wdata    = '0;

  // predictor state
  logic [PH_W-1:0]  seq_phase = PH_IDLE;
  logic [2:0]       seq_bit   = '0;
  logic [7:0]       seq_shift = '0;
  logic [1:0]       seq_byte  = BYTE_MODE;
  logic [POS_W-1:0] lat_pos   = '0;
  logic [7:0]       lat_seg   = '0;
  logic             ack_flag  = 1'b0;
  logic [1:0]       line_drv  = '0;
  logic [2:0]       bright    = BRIGHT_RST;

  ldw_res_t pending_ticks [$];
  int       mismatch_count = 0;
  int       result_index   = 0;
  int       tick_count     = 0;
  int       burst_left     = 0;
  int       stall_left     = 0;
  int       stall_mode     = 0;
  int       stall_cyc      = 0;

  led_driver_two_wire_write_master_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_request       (in_request),
    .in_position      (in_position),
    .in_segments      (in_segments),
    .in_dio_sense     (in_dio_sense),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_clk_pull_low (out_clk_pull_low),
    .out_dio_pull_low (out_dio_pull_low),
    .out_busy_res     (out_busy_res),
    .out_done_res     (out_done_res),
    .out_ack_missing  (out_ack_missing),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  task automatic flag_mismatch(input string msg);
    if (mismatch_count < 40) $display("tb_top: mismatch: %s", msg);
    mismatch_count++;
  endtask

  task automatic load_frame(input logic [1:0] n);
    seq_byte = n;
    case (n)
      BYTE_MODE: seq_shift = CMD_MODE;
      BYTE_ADDR: seq_shift = CMD_ADDR | 8'(lat_pos);
      BYTE_DATA: seq_shift = lat_seg;
      default:   seq_shift = CMD_CTRL | {5'b0, bright};
    endcase
    seq_bit   = '0;
    seq_phase = PH_BITA;
  endtask

  task automatic predict_tick(input logic req, input logic [POS_W-1:0] pos,
                              input logic [7:0] seg, input logic sense, output ldw_res_t r);
    logic done;
    done = 1'b0;
    case (seq_phase)
      PH_IDLE: begin
        if (req) begin
          lat_pos  = pos;
          lat_seg  = seg;
          ack_flag = 1'b0;
          line_drv = '0;
          line_drv[DRV_DIO] = 1'b1;
          load_frame(BYTE_MODE);
        end else begin
          line_drv = '0;
        end
      end
      PH_BITA: begin
        line_drv[DRV_CLK] = 1'b1;
        seq_phase = PH_BITB;
      end
      PH_BITB: begin
        line_drv[DRV_DIO] = ~seq_shift[0];
        seq_phase = PH_BITC;
      end
      PH_BITC: begin
        line_drv[DRV_CLK] = 1'b0;
        seq_shift = seq_shift >> 1;
        if (seq_bit == 3'd7) begin
          seq_bit   = '0;
          seq_phase = PH_ACK0;
        end else begin
          seq_bit   = seq_bit + 3'd1;
          seq_phase = PH_BITA;
        end
      end
      PH_ACK0: begin
        line_drv = '0;
        line_drv[DRV_CLK] = 1'b1;
        seq_phase = PH_ACK1;
      end
      PH_ACK1: begin
        line_drv[DRV_CLK] = 1'b0;
        seq_phase = PH_ACK2;
      end
      PH_ACK2: begin
        if (!sense) line_drv[DRV_DIO] = 1'b1;
        else ack_flag = 1'b1;
        seq_phase = PH_ACK3;
      end
      PH_ACK3: begin
        line_drv[DRV_CLK] = 1'b1;
        if (seq_byte == BYTE_ADDR) load_frame(BYTE_DATA);
        else seq_phase = PH_STOP0;
      end
      PH_STOP0: begin
        line_drv[DRV_DIO] = 1'b1;
        seq_phase = PH_STOP1;
      end
      PH_STOP1: begin
        line_drv[DRV_CLK] = 1'b0;
        seq_phase = PH_STOP2;
      end
      PH_STOP2: begin
        line_drv = '0;
        if (seq_byte == BYTE_CTRL) begin
          seq_phase = PH_IDLE;
          seq_byte  = BYTE_MODE;
          done      = 1'b1;
        end else begin
          line_drv[DRV_DIO] = 1'b1;
          load_frame(seq_byte + 2'd1);
        end
      end
      default: begin
        seq_phase = PH_IDLE;
        line_drv  = '0;
      end
    endcase
    r.clk_pull_low = line_drv[DRV_CLK];
    r.dio_pull_low = line_drv[DRV_DIO];
    r.busy         = (seq_phase != PH_IDLE);
    r.done         = done;
    r.ack_missing  = ack_flag;
  endtask

  // one tick request; the sender works in bursts with gaps between them
  task automatic send_tick(input logic req, input logic [POS_W-1:0] pos, input logic [7:0] seg,
                           input logic sense, input logic typed, input ldw_res_t typed_res);
    ldw_res_t r;
    @(negedge clk);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_request   <= req;
    in_position  <= pos;
    in_segments  <= seg;
    in_dio_sense <= sense;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_tick(req, pos, seg, sense, r);
    pending_ticks.push_back(typed ? typed_res : r);
    tick_count++;
  endtask

  task automatic drain_all();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_ticks.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_brightness(input logic [2:0] v);
    drain_all();
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
    bright = v;
  endtask

  task automatic run_write(input logic [POS_W-1:0] pos, input logic [7:0] seg,
                           input logic [3:0] nack, input logic [1:0] busy_req,
                           input logic typed, input ldw_res_t first);
    logic req;
    logic sense;
    send_tick(1'b1, pos, seg, 1'($urandom_range(0, 1)), typed, first);
    while (seq_phase != PH_IDLE) begin
      sense = (seq_phase == PH_ACK2) ? nack[seq_byte] : 1'($urandom_range(0, 1));
      case (busy_req)
        BUSY_ALWAYS: req = 1'b1;
        BUSY_SOME:   req = ($urandom_range(0, 3) == 0);
        default:     req = 1'b0;
      endcase
      send_tick(req, POS_W'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), sense,
                1'b0, RES_IDLE);
    end
  endtask

  // receiver stall pattern
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 120);
    end
    stall_left--;
    stall_cyc++;
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 3) != 0);
      2:       out_ready <= ((stall_cyc % 8) < 5);
      default: out_ready <= 1'($urandom_range(0, 1));
    endcase
  end

  always @(posedge clk) begin
    ldw_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_ticks.size() == 0) begin
        flag_mismatch($sformatf("result %0d with no request pending", result_index));
      end else begin
        want = pending_ticks.pop_front();
        if (out_clk_pull_low !== want.clk_pull_low)
          flag_mismatch($sformatf("result %0d clk_pull_low %b, expected %b", result_index,
                                  out_clk_pull_low, want.clk_pull_low));
        if (out_dio_pull_low !== want.dio_pull_low)
          flag_mismatch($sformatf("result %0d dio_pull_low %b, expected %b", result_index,
                                  out_dio_pull_low, want.dio_pull_low));
        if (out_busy_res !== want.busy)
          flag_mismatch($sformatf("result %0d busy_res %b, expected %b", result_index,
                                  out_busy_res, want.busy));
        if (out_done_res !== want.done)
          flag_mismatch($sformatf("result %0d done_res %b, expected %b", result_index,
                                  out_done_res, want.done));
        if (out_ack_missing !== want.ack_missing)
          flag_mismatch($sformatf("result %0d ack_missing %b, expected %b", result_index,
                                  out_ack_missing, want.ack_missing));
      end
      result_index++;
    end
  end

  initial begin
    #5_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    int         i;
    int         p;
    int         phase_start;
    int         pick;
    logic [3:0] nack;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < NUM_ROWS; i++) begin
      if (dir_rows[i].bri != bright) set_brightness(dir_rows[i].bri);
      if (dir_rows[i].req)
        run_write(dir_rows[i].pos, dir_rows[i].seg, dir_rows[i].nack, dir_rows[i].busy_req,
                  dir_rows[i].typed, dir_rows[i].first);
      else
        send_tick(1'b0, dir_rows[i].pos, dir_rows[i].seg, 1'($urandom_range(0, 1)),
                  dir_rows[i].typed, dir_rows[i].first);
    end

    for (p = 0; p < 3; p++) begin
      set_brightness(bri_plan[p]);
      phase_start = tick_count;
      while (tick_count - phase_start < 100) begin
        repeat ($urandom_range(0, 3))
          send_tick(1'b0, POS_W'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)), 1'b0, RES_IDLE);
        pick = $urandom_range(0, 9);
        if (pick < 6) nack = 4'h0;
        else if (pick < 8) nack = 4'($urandom_range(0, 15));
        else nack = 4'hF;
        run_write(POS_W'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), nack,
                  2'($urandom_range(0, 2)), 1'b0, RES_IDLE);
        if ($urandom_range(0, 9) == 0) drain_all();
      end
    end

    drain_all();
    repeat (10) @(negedge clk);
    if (mismatch_count == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

endmodule
